### src/assert_macros.svh
// assertion helpers shared by the resampler modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/irr_pkg.sv
`timescale 1ns / 1ps

package irr_pkg;

   // default sizing
   localparam int IRR_MAX_RATE    = 16;
   localparam int IRR_SAMPLE_BITS = 16;

   // register file layout
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int RATE_W     = 5;

   typedef enum logic {
      REG_MODE = 1'b0,
      REG_RATE = 1'b1
   } reg_index_type;

   typedef enum logic {
      MODE_DECIMATE = 1'b0,
      MODE_INTERP   = 1'b1
   } mode_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;       // capture the request and the block context
      logic use_prev;   // interpolate against the stored previous sample
      logic div_step;   // one bit of the slope division
      logic emit;       // push one result into the output register
      logic emit_last;  // that result is the last of the request
   } irr_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic out_free;   // output register can take a result this cycle
   } irr_sts_type;

endpackage

### src/irr_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module irr_ctrl
   import irr_pkg::*;
#(
   parameter int MAX_RATE    = IRR_MAX_RATE,
   parameter int SAMPLE_BITS = IRR_SAMPLE_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_block_last,
   input  mode_type                         mode,
   input  logic [$clog2(MAX_RATE+1)-1:0]    rate,
   input  irr_sts_type                      sts,
   output irr_cmd_type                      cmd
);

   localparam int RW    = $clog2(MAX_RATE + 1);
   localparam int PW    = $clog2(MAX_RATE);
   localparam int CW    = $clog2(2 * MAX_RATE + 1);
   localparam int DBITS = SAMPLE_BITS + 1;
   localparam int DCW   = $clog2(DBITS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT
   } state_type;

   state_type       state_ff, state_in;
   logic            have_prev_ff, have_prev_in;
   logic [PW-1:0]   phase_ff, phase_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [DCW-1:0]  divc_ff, divc_in;

   logic            accept;
   logic            use_prev;
   logic [CW-1:0]   n_res;
   logic [CW-1:0]   rate_c;
   logic [RW-1:0]   phase_nx;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign use_prev  = (mode == MODE_INTERP) && have_prev_ff;
   assign rate_c    = CW'(rate);
   assign phase_nx  = RW'(phase_ff) + RW'(1);

   // number of results for the request being accepted
   always_comb begin
      if (mode == MODE_DECIMATE) begin
         n_res = (phase_ff == '0) ? CW'(1) : '0;
      end else if (have_prev_ff) begin
         n_res = req_block_last ? CW'(rate_c << 1) : rate_c;
      end else begin
         n_res = req_block_last ? rate_c : '0;
      end
   end

   // next state and counters
   always_comb begin
      state_in     = state_ff;
      have_prev_in = have_prev_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      divc_in      = divc_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load     = 1'b1;
               cmd.use_prev = use_prev;
               cnt_in       = n_res;
               divc_in      = DCW'(DBITS);
               // block context tracked in both modes
               if (req_block_last) begin
                  have_prev_in = 1'b0;
                  phase_in     = '0;
               end else begin
                  have_prev_in = 1'b1;
                  phase_in     = (phase_nx >= rate) ? '0 : phase_nx[PW-1:0];
               end
               if (n_res == '0) begin
                  state_in = ST_IDLE;
               end else if (use_prev) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            divc_in      = divc_ff - DCW'(1);
            if (divc_ff == DCW'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = (cnt_ff == CW'(1));
               cnt_in        = cnt_ff - CW'(1);
               if (cnt_ff == CW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         have_prev_ff <= 1'b0;
         phase_ff     <= '0;
         cnt_ff       <= '0;
         divc_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         have_prev_ff <= have_prev_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         divc_ff      <= divc_in;
      end
   end

   // checks
   `ASSERT_IMP(a_emit_has_count, cmd.emit, cnt_ff != '0, "result emitted with no count left")
   `ASSERT_NXT(a_div_to_emit, (state_ff == ST_DIV) && (divc_ff == DCW'(1)),
      state_ff == ST_EMIT, "division did not hand over to result output")
   `ASSERT_NXT(a_last_to_idle, cmd.emit_last, state_ff == ST_IDLE,
      "last result did not return to idle")

endmodule

### src/irr_dpath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module irr_dpath
   import irr_pkg::*;
#(
   parameter int MAX_RATE    = IRR_MAX_RATE,
   parameter int SAMPLE_BITS = IRR_SAMPLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   input  logic [$clog2(MAX_RATE+1)-1:0]       rate,
   input  irr_cmd_type                         cmd,
   output irr_sts_type                         sts,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]       rsp_sample_out,
   output logic                                rsp_run_last
);

   localparam int SB    = SAMPLE_BITS;
   localparam int RW    = $clog2(MAX_RATE + 1);
   localparam int DBITS = SB + 1;
   localparam int QW    = SB + 2;
   localparam int SW    = SB + 3;
   localparam logic signed [SW-1:0] SAT_MAX = {{(SW-SB+1){1'b0}}, {(SB-1){1'b1}}};
   localparam logic signed [SW-1:0] SAT_MIN = {{(SW-SB+1){1'b1}}, {(SB-1){1'b0}}};

   logic signed [SB-1:0]    prev_ff;
   logic signed [SB-1:0]    base_ff;
   logic                    neg_ff;
   logic [RW-1:0]           r_ff;
   logic [DBITS-1:0]        num_ff, num_in;
   logic [RW-1:0]           drem_ff, drem_in;
   logic [RW-1:0]           racc_ff, racc_in;
   logic [QW-1:0]           qacc_ff, qacc_in;
   logic                    rsp_valid_ff;
   logic signed [SB-1:0]    rsp_sample_ff;
   logic                    rsp_last_ff;

   logic signed [DBITS-1:0] diff;
   logic [DBITS-1:0]        mag;
   logic [RW:0]             trial;
   logic                    trial_ge;
   logic [RW:0]             rsum;
   logic                    rsum_ge;
   logic signed [SW-1:0]    base_ext;
   logic signed [SW-1:0]    q_ext;
   logic signed [SW-1:0]    sum_w;
   logic signed [SB-1:0]    sat_w;

   // slope of the request against the previous sample
   assign diff = {req_sample[SB-1], req_sample} - {prev_ff[SB-1], prev_ff};
   assign mag  = diff[DBITS-1] ? DBITS'(-diff) : DBITS'(diff);

   // restoring divider, one quotient bit per step
   assign trial    = {drem_ff, num_ff[DBITS-1]};
   assign trial_ge = (trial >= {1'b0, r_ff});

   // running quotient of |slope| * j / rate
   assign rsum    = {1'b0, racc_ff} + {1'b0, drem_ff};
   assign rsum_ge = (rsum >= {1'b0, r_ff});

   always_comb begin
      num_in  = num_ff;
      drem_in = drem_ff;
      racc_in = racc_ff;
      qacc_in = qacc_ff;
      if (cmd.load) begin
         num_in  = cmd.use_prev ? mag : '0;
         drem_in = '0;
         racc_in = '0;
         qacc_in = '0;
      end else if (cmd.div_step) begin
         num_in  = {num_ff[DBITS-2:0], trial_ge};
         drem_in = trial_ge ? RW'(trial - {1'b0, r_ff}) : trial[RW-1:0];
      end else if (cmd.emit) begin
         racc_in = rsum_ge ? RW'(rsum - {1'b0, r_ff}) : rsum[RW-1:0];
         qacc_in = qacc_ff + QW'(num_ff) + QW'(rsum_ge);
      end
   end

   // point value with saturation
   assign base_ext = {{(SW-SB){base_ff[SB-1]}}, base_ff};
   assign q_ext    = {1'b0, qacc_ff};
   assign sum_w    = neg_ff ? (base_ext - q_ext) : (base_ext + q_ext);

   always_comb begin
      if (sum_w > SAT_MAX) begin
         sat_w = SAT_MAX[SB-1:0];
      end else if (sum_w < SAT_MIN) begin
         sat_w = SAT_MIN[SB-1:0];
      end else begin
         sat_w = sum_w[SB-1:0];
      end
   end

   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   // request capture and arithmetic registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         prev_ff <= req_sample;
         base_ff <= cmd.use_prev ? prev_ff : req_sample;
         neg_ff  <= cmd.use_prev && diff[DBITS-1];
         r_ff    <= rate;
      end
      num_ff  <= num_in;
      drem_ff <= drem_in;
      racc_ff <= racc_in;
      qacc_ff <= qacc_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_sample_ff <= sat_w;
         rsp_last_ff   <= cmd.emit_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_run_last   = rsp_last_ff;

   // checks
   `ASSERT_IMP(a_rem_below_rate, cmd.emit, racc_ff < r_ff, "running remainder reached the rate")
   `ASSERT_IMP(a_emit_has_room, cmd.emit, sts.out_free, "result pushed into a full output register")

endmodule

### src/integer_rate_resampler_core.sv
`timescale 1ns / 1ps
// Integer-rate resampler: decimates or linearly interpolates 16-bit samples.
// Requests arrive on req_valid/req_ready carrying req_sample and
// req_block_last; results leave on rsp_valid/rsp_ready carrying
// rsp_sample_out and rsp_run_last, which flags the last result of a request.
// mode and rate are written through the APB-style register port; the user
// must write them only while idle; the block does not enforce it. Decimate:
// a dropped request gives no result, a kept one gives one. Interpolate with
// a previous sample: accept, bit-serial slope division, then rate results
// (2*rate on the last sample of a block), one per cycle through the output
// register unless stalled. The first sample of a block gives no result; a
// one-sample block gives rate copies of it. The first result follows the
// last divide step via the emit state into the output register. One request
// is in work at a time; the next is taken while the final result still waits
// in the output register. A stalled receiver holds the output register and
// the result sequence pauses without loss. Reset clears the block context,
// sets mode to decimate and rate to 1, and empties the output register.

module integer_rate_resampler_core
   import irr_pkg::*;
#(
   parameter int MAX_RATE    = IRR_MAX_RATE,
   parameter int SAMPLE_BITS = IRR_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_block_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                          rsp_run_last,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_W-1:0]         paddr,
   input  logic [CSR_DATA_W-1:0]         pwdata,
   output logic [CSR_DATA_W-1:0]         prdata,
   output logic                          pready
);

   localparam int RW   = $clog2(MAX_RATE + 1);
   localparam int CMPW = ((RW > RATE_W) ? RW : RATE_W) + 1;

   mode_type          mode_ff;
   logic [RATE_W-1:0] rate_ff;
   reg_index_type     reg_idx;
   logic              csr_wr;
   logic [CMPW-1:0]   rate_x;
   logic [RW-1:0]     rate_eff;
   irr_cmd_type       cmd;
   irr_sts_type       sts;

   // register port
   assign pready  = 1'b1;
   assign reg_idx = reg_index_type'(paddr[2]);
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_DECIMATE;
         rate_ff <= RATE_W'(1);
      end else if (csr_wr) begin
         case (reg_idx)
            REG_MODE: mode_ff <= mode_type'(pwdata[0]);
            REG_RATE: rate_ff <= pwdata[RATE_W-1:0];
            default:  mode_ff <= mode_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MODE: prdata = CSR_DATA_W'(mode_ff);
         REG_RATE: prdata = CSR_DATA_W'(rate_ff);
         default:  prdata = '0;
      endcase
   end

   // rate clamped to 1 .. MAX_RATE
   assign rate_x = CMPW'(rate_ff);

   always_comb begin
      if (rate_ff == '0) begin
         rate_eff = RW'(1);
      end else if (rate_x > CMPW'(MAX_RATE)) begin
         rate_eff = RW'(MAX_RATE);
      end else begin
         rate_eff = rate_x[RW-1:0];
      end
   end

   // sequencer
   irr_ctrl #(
      .MAX_RATE    (MAX_RATE),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_block_last (req_block_last),
      .mode           (mode_ff),
      .rate           (rate_eff),
      .sts            (sts),
      .cmd            (cmd)
   );

   // divider, point accumulator and output register
   irr_dpath #(
      .MAX_RATE    (MAX_RATE),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_sample     (req_sample),
      .rate           (rate_eff),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_run_last   (rsp_run_last)
   );

endmodule

### dv/integer_rate_resampler_core_tb.sv
`timescale 1ns / 1ps

module integer_rate_resampler_core_tb;
   import irr_pkg::*;

   localparam int SW          = IRR_SAMPLE_BITS;
   localparam longint SAT_HI  = (64'sd1 <<< (SW - 1)) - 1;
   localparam longint SAT_LO  = -SAT_HI - 1;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_WAIT  = 40;

   typedef struct {
      logic signed [SW-1:0] sample;
      logic                 block_last;
   } resampler_request_type;

   typedef struct {
      logic signed [SW-1:0] sample_out;
      logic                 run_last;
   } resampler_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic signed [SW-1:0]  req_sample = '0;
   logic                  req_block_last = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic signed [SW-1:0]  rsp_sample_out;
   logic                  rsp_run_last;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   integer_rate_resampler_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .req_block_last (req_block_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_run_last   (rsp_run_last),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // clock generation
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // pending requests and expected resampled points
   resampler_request_type pending_q[$];
   resampler_result_type  expected_points_q[$];

   // mirrored configuration and block context
   mode_type             mode_cfg = MODE_DECIMATE;
   logic [RATE_W-1:0]    rate_cfg = RATE_W'(1);
   logic signed [SW-1:0] prev_sample = '0;
   logic                 have_prev = 1'b0;
   logic [3:0]           decim_phase = '0;

   int  error_count = 0;
   int  accepted_requests = 0;
   int  checked_results = 0;
   int  send_gap = 0;
   int  stall_gap = 0;
   int  idle_cycles = 0;
   bit  idle_on = 1'b1;

   // interpolated point, truncated toward zero, saturated
   function automatic logic signed [SW-1:0] lerp_point(longint a, longint b, longint x,
                                                       longint r);
      longint v;
      v = a + ((b - a) * x) / r;
      if (v > SAT_HI) v = SAT_HI;
      else if (v < SAT_LO) v = SAT_LO;
      return v[SW-1:0];
   endfunction

   task automatic push_point(input logic signed [SW-1:0] v);
      resampler_result_type res;
      res.sample_out = v;
      res.run_last   = 1'b0;
      expected_points_q.push_back(res);
   endtask

   // compute the points one request produces and advance the block context
   task automatic predict_points(input logic signed [SW-1:0] cur, input logic last);
      int     first_idx;
      longint r;
      first_idx = expected_points_q.size();
      r = rate_cfg;
      if (r < 1) r = 1;
      if (r > IRR_MAX_RATE) r = IRR_MAX_RATE;
      if (mode_cfg == MODE_DECIMATE) begin
         if (decim_phase == 0) push_point(cur);
      end else if (have_prev) begin
         for (longint j = 0; j < r; j++) push_point(lerp_point(prev_sample, cur, j, r));
         if (last)
            for (longint j = 0; j < r; j++)
               push_point(lerp_point(prev_sample, cur, r + j, r));
      end else if (last) begin
         for (longint j = 0; j < r; j++) push_point(cur);
      end
      if (expected_points_q.size() > first_idx)
         expected_points_q[expected_points_q.size() - 1].run_last = 1'b1;
      prev_sample = cur;
      if (last) begin
         have_prev   = 1'b0;
         decim_phase = '0;
      end else begin
         have_prev = 1'b1;
         if (longint'(decim_phase) + 1 >= r) decim_phase = '0;
         else decim_phase = decim_phase + 1'b1;
      end
   endtask

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("%0t mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
      error_count++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_points(req_sample, req_block_last);
            accepted_requests++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               req_valid      <= 1'b1;
               req_sample     <= pending_q[0].sample;
               req_block_last <= pending_q[0].block_last;
               void'(pending_q.pop_front());
               if (idle_on && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 10);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_gap <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_points_q.size() == 0) begin
               report_mismatch("unexpected result", int'(rsp_sample_out), 0);
            end else begin
               if (rsp_sample_out !== expected_points_q[0].sample_out)
                  report_mismatch("sample_out", int'(rsp_sample_out),
                                  int'(expected_points_q[0].sample_out));
               if (rsp_run_last !== expected_points_q[0].run_last)
                  report_mismatch("run_last", int'(rsp_run_last),
                                  int'(expected_points_q[0].run_last));
               void'(expected_points_q.pop_front());
               checked_results++;
            end
         end
         if (stall_gap > 0) begin
            stall_gap <= stall_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0) stall_gap <= $urandom_range(1, 10);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // register write through the setup and access cycles
   task automatic write_csr(input reg_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(int'(idx) * 4);
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == REG_MODE) mode_cfg = mode_type'(val[0]);
      else rate_cfg = val[RATE_W-1:0];
   endtask

   // wait until the driver is drained and every expected point has come
   task automatic wait_drained();
      while (pending_q.size() != 0 || req_valid || expected_points_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic reconfigure(input mode_type m, input logic [RATE_W-1:0] r);
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      write_csr(REG_MODE, CSR_DATA_W'(m));
      write_csr(REG_RATE, CSR_DATA_W'(r));
   endtask

   task automatic queue_request(input int smp, input logic last);
      resampler_request_type rq;
      rq.sample     = smp[SW-1:0];
      rq.block_last = last;
      pending_q.push_back(rq);
   endtask

   // random blocks: mostly short well-formed blocks with mixed sample content
   task automatic queue_random_blocks(input int count);
      int n;
      int len;
      int smp;
      n   = 0;
      smp = 0;
      while (n < count) begin
         len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 6);
         for (int k = 0; k < len && n < count; k++) begin
            case ($urandom_range(0, 3))
               0: smp = $urandom_range(0, 65535);
               1: smp = $urandom_range(0, 1) ? int'(SAT_HI) : int'(SAT_LO);
               default: smp = smp + int'($urandom_range(0, 600)) - 300;
            endcase
            queue_request(smp, k == len - 1);
            n++;
         end
      end
   endtask

   // stimulus sequence
   initial begin
      logic [RATE_W-1:0] rate_pick [6];
      rate_pick = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd7, 5'd16};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: decimate by one, extremes pass through
      queue_request(int'(SAT_HI), 1'b0);
      queue_request(int'(SAT_LO), 1'b0);
      queue_request(0, 1'b0);
      queue_request(-1, 1'b1);

      // interpolate at full rate: saturating extrapolation both ways, one-sample block
      reconfigure(MODE_INTERP, 5'd16);
      queue_request(int'(SAT_LO), 1'b0);
      queue_request(int'(SAT_HI), 1'b1);
      queue_request(12345, 1'b1);
      queue_request(int'(SAT_HI), 1'b0);
      queue_request(int'(SAT_LO), 1'b1);

      // rate zero acts as one
      reconfigure(MODE_INTERP, 5'd0);
      queue_request(100, 1'b0);
      queue_request(-100, 1'b1);
      queue_request(7, 1'b1);

      // rate above the maximum saturates
      reconfigure(MODE_DECIMATE, 5'd31);
      queue_request(1, 1'b0);
      queue_request(2, 1'b0);
      queue_request(3, 1'b1);

      // rate and mode changed in the middle of a block
      reconfigure(MODE_INTERP, 5'd3);
      queue_request(10, 1'b0);
      queue_request(20, 1'b0);
      reconfigure(MODE_DECIMATE, 5'd2);
      queue_request(30, 1'b0);
      queue_request(40, 1'b0);
      queue_request(50, 1'b1);

      // random blocks over several settings, the last phase without idling
      for (int p = 0; p < 6; p++) begin
         reconfigure((p % 2) ? MODE_INTERP : MODE_DECIMATE,
                     (p == 4) ? RATE_W'($urandom_range(2, 15)) : rate_pick[p]);
         if (p == 5) idle_on = 1'b0;
         queue_random_blocks(8);
         // in the fourth setting the sender holds off until all points are back
         if (p == 3) wait_drained();
         queue_random_blocks(8);
      end

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("covered %0d requests and %0d resampled points", accepted_requests,
               checked_results);
      $display("both modes, rates 0 to 31, mid-block setting changes, random stalls");
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### integer_rate_resampler_core.f
+incdir+src
src/irr_pkg.sv
src/irr_ctrl.sv
src/irr_dpath.sv
src/integer_rate_resampler_core.sv
dv/integer_rate_resampler_core_tb.sv
